/* rtl/mcka_pkg.sv */
package mcka_pkg;

  localparam int CHANNELS = 6;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENCODER_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENCODER_MAX = 2'd1;

  localparam logic signed [15:0] ENCODER_MIN_RST = 16'sd0;
  localparam logic signed [15:0] ENCODER_MAX_RST = 16'sd100;

  // magnitude of (counter - min) * (max_angle - min_angle) fits in 34 bits
  localparam int DVD_W = 34;
  localparam int DVS_W = 17;

  typedef enum logic [1:0] {
    KIND_SAMPLE,
    KIND_LOAD,
    KIND_IGNORE
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [2:0]         channel;
    logic               clk_level;
    logic               dt_level;
    logic signed [15:0] load_counter;
    logic signed [15:0] load_min_angle;
    logic signed [15:0] load_max_angle;
    logic signed [15:0] load_angle;
  } req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [2:0]         channel;
    logic signed [15:0] counter_value;
    logic signed [15:0] angle_value;
    logic               moved;
    logic               direction_up;
  } result_t;

endpackage

/* rtl/mcka_front.sv */
module mcka_front
  import mcka_pkg::*;
(
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic [2:0]         in_channel,
  input  logic               in_clk_level,
  input  logic               in_dt_level,
  input  logic signed [15:0] in_load_counter,
  input  logic signed [15:0] in_load_min_angle,
  input  logic signed [15:0] in_load_max_angle,
  input  logic signed [15:0] in_load_angle,
  input  q_status_t          q_status,
  output logic               push,
  output req_t               push_req
);

  logic in_range;

  assign in_range = int'(in_channel) < CHANNELS;
  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_req.channel        = in_channel;
    push_req.clk_level      = in_clk_level;
    push_req.dt_level       = in_dt_level;
    push_req.load_counter   = in_load_counter;
    push_req.load_min_angle = in_load_min_angle;
    push_req.load_max_angle = in_load_max_angle;
    push_req.load_angle     = in_load_angle;
    if (!in_range) begin
      push_req.kind = KIND_IGNORE;
    end else if (in_func) begin
      push_req.kind = KIND_LOAD;
    end else begin
      push_req.kind = KIND_SAMPLE;
    end
  end

endmodule

/* rtl/mcka_queue.sv */
module mcka_queue
  import mcka_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  req_t      push_req,
  input  logic      pop,
  output req_t      pop_req,
  output q_status_t status
);

  localparam int DEPTH = 2;

  req_t       mem_r [DEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign status.full  = count_r == 2'(DEPTH);
  assign status.empty = count_r == 2'd0;
  assign pop_req      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        mem_r[wr_ptr_r] <= push_req;
        wr_ptr_r        <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* rtl/mcka_back.sv */
module mcka_back
  import mcka_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [15:0] encoder_min,
  input  logic signed [15:0] encoder_max,
  input  q_status_t          q_status,
  input  req_t               pop_req,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output result_t            out_res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_DIV,
    S_FIN,
    S_DONE
  } state_t;

  localparam logic [5:0] DIV_LAST = 6'(DVD_W - 1);

  state_t             state_r;
  req_t               req_r;
  result_t            res_r;
  result_t            out_r;
  logic               out_valid_r;
  logic               last_clk_r;

  logic signed [15:0] counter_table_r   [CHANNELS];
  logic signed [15:0] angle_table_r     [CHANNELS];
  logic signed [15:0] min_angle_table_r [CHANNELS];
  logic signed [15:0] max_angle_table_r [CHANNELS];

  logic signed [15:0] cnt_r;
  logic signed [15:0] lo_r;
  logic signed [15:0] hi_r;
  logic               neg_r;
  logic [DVS_W-1:0]   dvs_r;
  logic [DVD_W-1:0]   dvd_r;
  logic [DVS_W-1:0]   rem_r;
  logic [5:0]         div_cnt_r;

  logic [CH_IDX_W-1:0] idx;
  logic signed [15:0]  cur_cnt;
  logic                step_up;
  logic signed [15:0]  new_cnt;
  logic signed [16:0]  span;
  logic signed [16:0]  x_off;
  logic signed [16:0]  ang_span;
  logic signed [33:0]  prod;
  logic [DVS_W:0]      rem_sh;
  logic                rem_ge;
  logic signed [35:0]  quo_s;
  logic signed [35:0]  ang_sum;
  logic signed [15:0]  ang_sat;
  logic                out_load;

  assign idx     = req_r.channel[CH_IDX_W-1:0];
  assign cur_cnt = counter_table_r[idx];
  assign step_up = req_r.dt_level != req_r.clk_level;
  assign span    = 17'(encoder_max) - 17'(encoder_min);

  always_comb begin
    new_cnt = cur_cnt;
    if (step_up) begin
      if (cur_cnt < encoder_max) new_cnt = cur_cnt + 16'sd1;
    end else if (cur_cnt > encoder_min) begin
      new_cnt = cur_cnt - 16'sd1;
    end
  end

  assign x_off    = 17'(cnt_r) - 17'(encoder_min);
  assign ang_span = 17'(hi_r) - 17'(lo_r);
  assign prod     = 34'(x_off) * 34'(ang_span);

  // restoring divide, one quotient bit per cycle shifted into dvd_r
  assign rem_sh = {rem_r, dvd_r[DVD_W-1]};
  assign rem_ge = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    quo_s = neg_r ? -$signed({2'b00, dvd_r}) : $signed({2'b00, dvd_r});
    ang_sum = quo_s + 36'(lo_r);
    if (ang_sum > 36'sd32767) begin
      ang_sat = 16'sh7FFF;
    end else if (ang_sum < -36'sd32768) begin
      ang_sat = 16'sh8000;
    end else begin
      ang_sat = ang_sum[15:0];
    end
  end

  assign pop       = (state_r == S_IDLE) && !q_status.empty;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      last_clk_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (pop) begin
            req_r   <= pop_req;
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          res_r.channel <= req_r.channel;
          case (req_r.kind)
            KIND_LOAD: begin
              counter_table_r[idx]   <= req_r.load_counter;
              angle_table_r[idx]     <= req_r.load_angle;
              min_angle_table_r[idx] <= req_r.load_min_angle;
              max_angle_table_r[idx] <= req_r.load_max_angle;
              res_r.counter_value    <= req_r.load_counter;
              res_r.angle_value      <= req_r.load_angle;
              res_r.moved            <= 1'b0;
              res_r.direction_up     <= 1'b0;
              state_r                <= S_DONE;
            end
            KIND_SAMPLE: begin
              if (req_r.clk_level == last_clk_r) begin
                res_r.counter_value <= cur_cnt;
                res_r.angle_value   <= angle_table_r[idx];
                res_r.moved         <= 1'b0;
                res_r.direction_up  <= 1'b0;
                state_r             <= S_DONE;
              end else begin
                counter_table_r[idx] <= new_cnt;
                last_clk_r           <= req_r.clk_level;
                res_r.counter_value  <= new_cnt;
                res_r.moved          <= 1'b1;
                res_r.direction_up   <= step_up;
                cnt_r                <= new_cnt;
                lo_r                 <= min_angle_table_r[idx];
                hi_r                 <= max_angle_table_r[idx];
                if (span == 17'sd0) begin
                  angle_table_r[idx] <= min_angle_table_r[idx];
                  res_r.angle_value  <= min_angle_table_r[idx];
                  state_r            <= S_DONE;
                end else begin
                  state_r <= S_MUL;
                end
              end
            end
            default: begin
              res_r.counter_value <= 16'sd0;
              res_r.angle_value   <= 16'sd0;
              res_r.moved         <= 1'b0;
              res_r.direction_up  <= 1'b0;
              state_r             <= S_DONE;
            end
          endcase
        end
        S_MUL: begin
          dvd_r     <= prod[33] ? DVD_W'(-prod) : DVD_W'(prod);
          dvs_r     <= span[16] ? DVS_W'(-span) : DVS_W'(span);
          neg_r     <= prod[33] ^ span[16];
          rem_r     <= '0;
          div_cnt_r <= DIV_LAST;
          state_r   <= S_DIV;
        end
        S_DIV: begin
          // remainder stays below the divisor, so the top bit drops out
          rem_r     <= rem_ge ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];
          dvd_r     <= {dvd_r[DVD_W-2:0], rem_ge};
          div_cnt_r <= div_cnt_r - 6'd1;
          if (div_cnt_r == 6'd0) state_r <= S_FIN;
        end
        S_FIN: begin
          angle_table_r[idx] <= ang_sat;
          res_r.angle_value  <= ang_sat;
          state_r            <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_r   <= res_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/multi_channel_knob_angle_mapper_core.sv */
// Loads, ignored channels and samples without a clock change go from evaluate
// straight to done; a moving sample adds a 17x17 multiply and then a 34-step
// restoring divider, one quotient bit per cycle, unless encoder span is zero.
// The back end takes one request at a time and pops the next only after the
// result is handed to the output; a two-entry queue takes requests meanwhile.
// Reset (synchronous, rst_n low): encoder limits 0 and 100, last clock level 0,
// queue and output emptied; channel tables hold nothing until loaded.
module multi_channel_knob_angle_mapper_core
  import mcka_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_func,
  input  logic [2:0]           in_channel,
  input  logic                 in_clk_level,
  input  logic                 in_dt_level,
  input  logic signed [15:0]   in_load_counter,
  input  logic signed [15:0]   in_load_min_angle,
  input  logic signed [15:0]   in_load_max_angle,
  input  logic signed [15:0]   in_load_angle,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_channel,
  output logic signed [15:0]   out_counter_value,
  output logic signed [15:0]   out_angle_value,
  output logic                 out_moved,
  output logic                 out_direction_up,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  logic signed [15:0] encoder_min_r;
  logic signed [15:0] encoder_max_r;
  q_status_t          q_status;
  logic               push;
  req_t               push_req;
  logic               pop;
  req_t               pop_req;
  result_t            out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      encoder_min_r <= ENCODER_MIN_RST;
      encoder_max_r <= ENCODER_MAX_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ENCODER_MIN: encoder_min_r <= cfg_data;
        CFG_ENCODER_MAX: encoder_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  mcka_front u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_channel        (in_channel),
    .in_clk_level      (in_clk_level),
    .in_dt_level       (in_dt_level),
    .in_load_counter   (in_load_counter),
    .in_load_min_angle (in_load_min_angle),
    .in_load_max_angle (in_load_max_angle),
    .in_load_angle     (in_load_angle),
    .q_status          (q_status),
    .push              (push),
    .push_req          (push_req)
  );

  mcka_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .pop_req  (pop_req),
    .status   (q_status)
  );

  mcka_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .encoder_min (encoder_min_r),
    .encoder_max (encoder_max_r),
    .q_status    (q_status),
    .pop_req     (pop_req),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_res     (out_res)
  );

  assign out_channel       = out_res.channel;
  assign out_counter_value = out_res.counter_value;
  assign out_angle_value   = out_res.angle_value;
  assign out_moved         = out_res.moved;
  assign out_direction_up  = out_res.direction_up;

endmodule

/* tb/multi_channel_knob_angle_mapper_core_test.sv */
`timescale 1ns / 100ps

module multi_channel_knob_angle_mapper_core_test;
  import mcka_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 45;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_REQUESTS = 190;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_func;
  logic [2:0]           in_channel;
  logic                 in_clk_level;
  logic                 in_dt_level;
  logic signed [15:0]   in_load_counter;
  logic signed [15:0]   in_load_min_angle;
  logic signed [15:0]   in_load_max_angle;
  logic signed [15:0]   in_load_angle;
  logic                 out_valid;
  logic                 out_ready;
  logic [2:0]           out_channel;
  logic signed [15:0]   out_counter_value;
  logic signed [15:0]   out_angle_value;
  logic                 out_moved;
  logic                 out_direction_up;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  multi_channel_knob_angle_mapper_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_channel        (in_channel),
    .in_clk_level      (in_clk_level),
    .in_dt_level       (in_dt_level),
    .in_load_counter   (in_load_counter),
    .in_load_min_angle (in_load_min_angle),
    .in_load_max_angle (in_load_max_angle),
    .in_load_angle     (in_load_angle),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_channel       (out_channel),
    .out_counter_value (out_counter_value),
    .out_angle_value   (out_angle_value),
    .out_moved         (out_moved),
    .out_direction_up  (out_direction_up),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // knob state as the block should hold it
  logic signed [15:0] knob_count [CHANNELS];
  logic signed [15:0] knob_angle [CHANNELS];
  logic signed [15:0] angle_lo [CHANNELS];
  logic signed [15:0] angle_hi [CHANNELS];
  logic               last_level;
  logic signed [15:0] enc_lo;
  logic signed [15:0] enc_hi;

  result_t pending_results [$];
  int      error_count;
  int      cycle_count;
  bit      send_gaps_on;
  bit      recv_stalls_on;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("multi_channel_knob_angle_mapper_core_test: errors");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= 100) $display("cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic logic signed [15:0] angle_for_count(logic signed [15:0] cnt,
                                                         logic signed [15:0] lo,
                                                         logic signed [15:0] hi);
    longint span;
    longint scaled;
    span = longint'(enc_hi) - longint'(enc_lo);
    if (span == 0) return lo;
    scaled = (longint'(cnt) - longint'(enc_lo)) * (longint'(hi) - longint'(lo)) / span
             + longint'(lo);
    if (scaled > 32767) return 16'sh7fff;
    if (scaled < -32768) return 16'sh8000;
    return scaled[15:0];
  endfunction

  function automatic result_t advance_knob(logic func, logic [2:0] ch, logic clk_lvl,
                                           logic dt_lvl, logic signed [15:0] ld_cnt,
                                           logic signed [15:0] ld_lo,
                                           logic signed [15:0] ld_hi,
                                           logic signed [15:0] ld_ang);
    result_t res;
    logic signed [15:0] cnt;
    res = '0;
    res.channel = ch;
    if (ch >= CHANNELS) return res;
    if (func) begin
      knob_count[ch] = ld_cnt;
      angle_lo[ch]   = ld_lo;
      angle_hi[ch]   = ld_hi;
      knob_angle[ch] = ld_ang;
    end else if (clk_lvl != last_level) begin
      cnt = knob_count[ch];
      res.moved = 1'b1;
      res.direction_up = (dt_lvl != clk_lvl);
      if (res.direction_up) begin
        if (cnt < enc_hi) cnt = cnt + 16'sd1;
      end else if (cnt > enc_lo) begin
        cnt = cnt - 16'sd1;
      end
      knob_count[ch] = cnt;
      knob_angle[ch] = angle_for_count(cnt, angle_lo[ch], angle_hi[ch]);
      last_level = clk_lvl;
    end
    res.counter_value = knob_count[ch];
    res.angle_value   = knob_angle[ch];
    return res;
  endfunction

  task automatic send_request(logic func, logic [2:0] ch, logic clk_lvl, logic dt_lvl,
                              logic signed [15:0] ld_cnt, logic signed [15:0] ld_lo,
                              logic signed [15:0] ld_hi, logic signed [15:0] ld_ang);
    int gap;
    gap = send_gaps_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_func           <= func;
    in_channel        <= ch;
    in_clk_level      <= clk_lvl;
    in_dt_level       <= dt_lvl;
    in_load_counter   <= ld_cnt;
    in_load_min_angle <= ld_lo;
    in_load_max_angle <= ld_hi;
    in_load_angle     <= ld_ang;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(advance_knob(func, ch, clk_lvl, dt_lvl, ld_cnt, ld_lo,
                                           ld_hi, ld_ang));
  endtask

  task automatic send_load(logic [2:0] ch, logic signed [15:0] cnt,
                           logic signed [15:0] lo, logic signed [15:0] hi,
                           logic signed [15:0] ang);
    send_request(1'b1, ch, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 cnt, lo, hi, ang);
  endtask

  task automatic send_sample(logic [2:0] ch, logic clk_lvl, logic dt_lvl);
    send_request(1'b0, ch, clk_lvl, dt_lvl, 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom));
  endtask

  // lowers valid right after the last request, then lets the back end go quiet
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves valid high; the caller drops it after its last write
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ENCODER_MIN: enc_lo = data;
      CFG_ENCODER_MAX: enc_hi = data;
      default: ;
    endcase
  endtask

  task automatic set_encoder_limits(logic signed [15:0] lo, logic signed [15:0] hi);
    wait_idle();
    cfg_write(CFG_ENCODER_MIN, lo);
    cfg_write(CFG_ENCODER_MAX, hi);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sd0;
      3: return -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_count();
    case ($urandom_range(0, 5))
      0: return enc_lo;
      1: return enc_hi;
      2: return enc_lo + 16'sd1;
      3: return enc_hi - 16'sd1;
      4: return pick_word();
      default: return 16'((longint'(enc_lo) + longint'(enc_hi)) / 2);
    endcase
  endfunction

  // every channel gets loaded here so later samples never touch an empty table entry
  task automatic test_channel_loads();
    send_load(3'd0, 16'sd50, -16'sd1000, 16'sd1000, 16'sd0);
    send_load(3'd1, 16'sd0, 16'sd0, 16'sd360, 16'sd7);
    send_load(3'd2, 16'sd100, 16'sh8000, 16'sh7fff, 16'sh7fff);
    send_load(3'd3, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
    send_load(3'd4, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sd0);
    send_load(3'd5, -16'sd5, 16'sd300, -16'sd300, 16'sd1);
    send_load(3'd7, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
    send_sample(3'd6, 1'b1, 1'b0);
  endtask

  task automatic test_step_and_clamp();
    send_sample(3'd0, 1'b1, 1'b0);
    send_sample(3'd0, 1'b1, 1'b1);
    send_sample(3'd2, 1'b0, 1'b0);
    send_sample(3'd2, 1'b1, 1'b0);
    send_sample(3'd2, 1'b0, 1'b1);
    send_sample(3'd1, 1'b1, 1'b1);
    send_sample(3'd3, 1'b0, 1'b0);
    send_sample(3'd4, 1'b1, 1'b0);
    send_sample(3'd5, 1'b0, 1'b1);
    send_sample(3'd6, 1'b1, 1'b1);
    send_sample(3'd7, 1'b0, 1'b0);
  endtask

  task automatic test_limit_corners();
    set_encoder_limits(16'sd7, 16'sd7);
    send_sample(3'd0, 1'b1, 1'b0);
    send_sample(3'd1, 1'b0, 1'b0);
    set_encoder_limits(16'sh8000, 16'sh7fff);
    send_sample(3'd2, 1'b1, 1'b0);
    send_sample(3'd3, 1'b0, 1'b1);
    set_encoder_limits(16'sh7fff, 16'sh8000);
    send_sample(3'd4, 1'b1, 1'b1);
    send_sample(3'd5, 1'b0, 1'b1);
  endtask

  task automatic test_random_traffic();
    logic signed [15:0] lo_set [RANDOM_PHASES];
    logic signed [15:0] hi_set [RANDOM_PHASES];
    int roll;
    logic [2:0] ch;
    logic lvl;
    lo_set = '{16'sd0, -16'sd5, 16'sh8000, 16'sd3, 16'sh7fff, -16'sd100, 16'sd0, 16'sd0};
    hi_set = '{16'sd100, 16'sd5, 16'sh7fff, 16'sd3, 16'sh8000, -16'sd90, 16'sd0, 16'sd0};
    lo_set[6] = 16'($urandom);
    hi_set[6] = 16'($urandom);
    lo_set[7] = 16'(int'($urandom_range(0, 200)) - 100);
    hi_set[7] = 16'(int'(lo_set[7]) + int'($urandom_range(0, 40)));
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_encoder_limits(lo_set[p], hi_set[p]);
      send_gaps_on   = (p == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      recv_stalls_on = (p == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          // channels past the last one: ignored by the block
          send_request(1'($urandom_range(0, 1)), 3'($urandom_range(CHANNELS, 7)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end else if (roll < 20) begin
          send_load(3'($urandom_range(0, CHANNELS - 1)), pick_count(), pick_word(),
                    pick_word(), pick_word());
        end else begin
          ch = 3'($urandom_range(0, CHANNELS - 1));
          lvl = ($urandom_range(0, 3) != 0) ? ~last_level : last_level;
          send_sample(ch, lvl, 1'($urandom_range(0, 1)));
        end
      end
    end
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
  endtask

  initial begin : result_monitor
    int stall;
    result_t want;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = recv_stalls_on ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result on channel %0d", out_channel));
      end else begin
        want = pending_results.pop_front();
        if (out_channel !== want.channel)
          report_mismatch($sformatf("channel %0d, want %0d", out_channel, want.channel));
        if (out_counter_value !== want.counter_value)
          report_mismatch($sformatf("ch %0d counter %0d, want %0d", want.channel,
                                    out_counter_value, want.counter_value));
        if (out_angle_value !== want.angle_value)
          report_mismatch($sformatf("ch %0d angle %0d, want %0d", want.channel,
                                    out_angle_value, want.angle_value));
        if (out_moved !== want.moved)
          report_mismatch($sformatf("ch %0d moved %b, want %b", want.channel,
                                    out_moved, want.moved));
        if (out_direction_up !== want.direction_up)
          report_mismatch($sformatf("ch %0d direction_up %b, want %b", want.channel,
                                    out_direction_up, want.direction_up));
      end
    end
  end

  initial begin
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_func           <= 1'b0;
    in_channel        <= '0;
    in_clk_level      <= 1'b0;
    in_dt_level       <= 1'b0;
    in_load_counter   <= '0;
    in_load_min_angle <= '0;
    in_load_max_angle <= '0;
    in_load_angle     <= '0;
    cfg_valid         <= 1'b0;
    cfg_index         <= CFG_ENCODER_MIN;
    cfg_data          <= '0;
    error_count       = 0;
    cycle_count       = 0;
    send_gaps_on      = 1'b1;
    recv_stalls_on    = 1'b1;
    enc_lo            = ENCODER_MIN_RST;
    enc_hi            = ENCODER_MAX_RST;
    last_level        = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      knob_count[i] = '0;
      knob_angle[i] = '0;
      angle_lo[i]   = '0;
      angle_hi[i]   = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_channel_loads();
    test_step_and_clamp();
    test_limit_corners();
    test_random_traffic();
    wait_idle();

    if (error_count == 0) begin
      $display("multi_channel_knob_angle_mapper_core_test: clean");
    end else begin
      $display("multi_channel_knob_angle_mapper_core_test: errors");
    end
    $finish;
  end

endmodule
